FILE: hdl/nlrp_pkg.sv
// Shared constants for the nearest-LBA request promotion block.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package nlrp_pkg;

  // Fixed item field widths
  localparam int LEVEL_W    = 3;
  localparam int COUNT_W    = 16;
  localparam int VALID_W    = 4;
  localparam int IDX_W      = 3;
  localparam int LBA_PORT_W = 48;

  // Number of LBA fields carried by one item (one lane each)
  localparam int LBA_FIELDS = 8;

  // Register reset value
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd32;

  // Parameter defaults
  localparam int SCAN_WINDOW_DEF = 8;
  localparam int LEVELS_DEF      = 5;
  localparam int LBA_BITS_DEF    = 48;

endpackage

FILE: hdl/nlrp_lane.sv
// One distance lane: absolute LBA difference to the level reference, registered.
// Depends on nlrp_pkg for the default LBA width.
`timescale 1ns / 1ps

module nlrp_lane #(
  parameter int LW = nlrp_pkg::LBA_BITS_DEF
) (
  input  logic          clk,
  input  logic          load,
  input  logic          vld_in,
  input  logic [LW-1:0] lba_in,
  input  logic [LW-1:0] ref_in,
  output logic          vld,
  output logic [LW-1:0] span,
  output logic [LW-1:0] lba
);

  logic          vld_r;
  logic [LW-1:0] span_r;
  logic [LW-1:0] lba_r;
  logic [LW-1:0] span_nxt;

  // true absolute difference
  always_comb begin
    if (lba_in > ref_in) begin
      span_nxt = lba_in - ref_in;
    end else begin
      span_nxt = ref_in - lba_in;
    end
  end

  // payload stage register, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      vld_r  <= vld_in;
      span_r <= span_nxt;
      lba_r  <= lba_in;
    end
  end

  assign vld  = vld_r;
  assign span = span_r;
  assign lba  = lba_r;

endmodule

FILE: hdl/nlrp_pick.sv
// Merge node: keeps the nearer of two candidates, the left (earlier) one on ties.
// Depends on nlrp_pkg for the index width.
`timescale 1ns / 1ps

module nlrp_pick #(
  parameter int LW = nlrp_pkg::LBA_BITS_DEF
) (
  input  logic                       a_vld,
  input  logic [nlrp_pkg::IDX_W-1:0] a_idx,
  input  logic [LW-1:0]              a_dist,
  input  logic [LW-1:0]              a_lba,
  input  logic                       b_vld,
  input  logic [nlrp_pkg::IDX_W-1:0] b_idx,
  input  logic [LW-1:0]              b_dist,
  input  logic [LW-1:0]              b_lba,
  output logic                       y_vld,
  output logic [nlrp_pkg::IDX_W-1:0] y_idx,
  output logic [LW-1:0]              y_dist,
  output logic [LW-1:0]              y_lba
);

  logic take_a;

  // left wins if valid, unless right is valid and strictly nearer
  assign take_a = a_vld && (!b_vld || (a_dist <= b_dist));

  assign y_vld  = a_vld || b_vld;
  assign y_idx  = take_a ? a_idx  : b_idx;
  assign y_dist = take_a ? a_dist : b_dist;
  assign y_lba  = take_a ? a_lba  : b_lba;

endmodule

FILE: hdl/nearest_lba_request_promote.sv
// Nearest-LBA request promotion: each item is one priority level's queue snapshot and yields
// exactly one result. Items are accepted one per cycle unless a level hazard or a stalled
// output holds in_ready low. Each item passes the distance lanes (loaded on the accepting edge),
// a two-level merge into the stage-2 registers, then the final merge into the output register.
// The per-level reference LBA is written by the final merge stage, so an item whose level
// matches a pass still in the lane or merge stage waits at in_ready until that pass completes,
// which a stalled output delays. The pass decision and the per-level count update happen in
// the accept cycle. cfg_ready is always high; the threshold should only be written while no
// item is in flight.
`timescale 1ns / 1ps

module nearest_lba_request_promote #(
  parameter int SCAN_WINDOW = nlrp_pkg::SCAN_WINDOW_DEF,
  parameter int LEVELS      = nlrp_pkg::LEVELS_DEF,
  parameter int LBA_BITS    = nlrp_pkg::LBA_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [nlrp_pkg::COUNT_W-1:0]    cfg_data,
  // input items
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [nlrp_pkg::LEVEL_W-1:0]    in_level,
  input  logic                            in_dirty,
  input  logic [nlrp_pkg::COUNT_W-1:0]    in_request_count,
  input  logic [nlrp_pkg::VALID_W-1:0]    in_entries_valid,
  input  logic [nlrp_pkg::LBA_PORT_W-1:0] in_lba_0,
  input  logic [nlrp_pkg::LBA_PORT_W-1:0] in_lba_1,
  input  logic [nlrp_pkg::LBA_PORT_W-1:0] in_lba_2,
  input  logic [nlrp_pkg::LBA_PORT_W-1:0] in_lba_3,
  input  logic [nlrp_pkg::LBA_PORT_W-1:0] in_lba_4,
  input  logic [nlrp_pkg::LBA_PORT_W-1:0] in_lba_5,
  input  logic [nlrp_pkg::LBA_PORT_W-1:0] in_lba_6,
  input  logic [nlrp_pkg::LBA_PORT_W-1:0] in_lba_7,
  // result items
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_reordered,
  output logic [nlrp_pkg::IDX_W-1:0]      out_chosen_index,
  output logic [nlrp_pkg::LBA_PORT_W-1:0] out_head_lba
);

  localparam int NL     = nlrp_pkg::LBA_FIELDS;
  localparam int IW     = nlrp_pkg::IDX_W;
  localparam int CW     = nlrp_pkg::COUNT_W;
  localparam int VW     = nlrp_pkg::VALID_W;
  localparam int PW     = nlrp_pkg::LBA_PORT_W;
  localparam int LVW    = nlrp_pkg::LEVEL_W;
  localparam int LW     = (LBA_BITS < PW) ? LBA_BITS : PW;
  localparam int WINDOW = (SCAN_WINDOW < NL) ? SCAN_WINDOW : NL;
  localparam int LIDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

  // configuration register
  logic [CW-1:0] threshold_r;

  // per-level state
  logic [CW-1:0] count_r [LEVELS];
  logic [LW-1:0] head_r  [LEVELS];

  // pipeline control
  logic           s1_v_r, s2_v_r, out_valid_r;
  logic           s1_pass_r, s2_pass_r;
  logic [LVW-1:0] s1_lvl_r, s2_lvl_r;
  logic           out_take, s2_en, s1_en, hazard, in_fire;

  // accept-cycle decision
  logic              lvl_ok;
  logic [LIDX_W-1:0] lidx;
  logic [VW-1:0]     vcnt;
  logic [CW-1:0]     prev_cnt, delta;
  logic              pass_nxt;
  logic [LW-1:0]     ref_lba;
  logic [LW-1:0]     lba_in [NL];

  // lane outputs
  logic          l_vld  [NL];
  logic [LW-1:0] l_dist [NL];
  logic [LW-1:0] l_lba  [NL];

  // first merge level
  logic          n1_vld  [NL/2];
  logic [IW-1:0] n1_idx  [NL/2];
  logic [LW-1:0] n1_dist [NL/2];
  logic [LW-1:0] n1_lba  [NL/2];

  // second merge level, registered
  logic          n2_vld  [2];
  logic [IW-1:0] n2_idx  [2];
  logic [LW-1:0] n2_dist [2];
  logic [LW-1:0] n2_lba  [2];
  logic          s2_vld_r  [2];
  logic [IW-1:0] s2_idx_r  [2];
  logic [LW-1:0] s2_dist_r [2];
  logic [LW-1:0] s2_lba_r  [2];

  // final merge
  logic          fin_vld;
  logic [IW-1:0] fin_idx;
  logic [LW-1:0] fin_lba;

  // output register
  logic          out_reordered_r;
  logic [IW-1:0] out_idx_r;
  logic [PW-1:0] out_lba_r;

  // stage flow: each stage loads when empty or when it empties this cycle
  assign out_take = !out_valid_r || out_ready;
  assign s2_en    = !s2_v_r || out_take;
  assign s1_en    = !s1_v_r || s2_en;

  // a pass in flight on this level has not yet written its reference LBA
  assign hazard = (s1_v_r && s1_pass_r && (s1_lvl_r == in_level)) ||
                  (s2_v_r && s2_pass_r && (s2_lvl_r == in_level));
  assign in_ready  = s1_en && !hazard;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // pass decision
  assign lvl_ok   = (int'(in_level) < LEVELS);
  assign lidx     = LIDX_W'(in_level);
  assign vcnt     = (int'(in_entries_valid) > WINDOW) ? VW'(WINDOW) : in_entries_valid;
  assign prev_cnt = count_r[lidx];
  assign delta    = (in_request_count > prev_cnt) ? (in_request_count - prev_cnt)
                                                  : (prev_cnt - in_request_count);
  assign pass_nxt = lvl_ok && in_dirty && (vcnt >= VW'(2)) && (delta >= threshold_r);
  assign ref_lba  = head_r[lidx];

  assign lba_in[0] = in_lba_0[LW-1:0];
  assign lba_in[1] = in_lba_1[LW-1:0];
  assign lba_in[2] = in_lba_2[LW-1:0];
  assign lba_in[3] = in_lba_3[LW-1:0];
  assign lba_in[4] = in_lba_4[LW-1:0];
  assign lba_in[5] = in_lba_5[LW-1:0];
  assign lba_in[6] = in_lba_6[LW-1:0];
  assign lba_in[7] = in_lba_7[LW-1:0];

  // distance lanes
  for (genvar i = 0; i < NL; i++) begin : g_lane
    nlrp_lane #(.LW(LW)) u_lane (
      .clk    (clk),
      .load   (in_fire),
      .vld_in (VW'(i) < vcnt),
      .lba_in (lba_in[i]),
      .ref_in (ref_lba),
      .vld    (l_vld[i]),
      .span   (l_dist[i]),
      .lba    (l_lba[i])
    );
  end

  // merge tree, first level
  for (genvar k = 0; k < NL/2; k++) begin : g_m1
    nlrp_pick #(.LW(LW)) u_pick (
      .a_vld (l_vld[2*k]),   .a_idx (IW'(2*k)),
      .a_dist(l_dist[2*k]),  .a_lba (l_lba[2*k]),
      .b_vld (l_vld[2*k+1]), .b_idx (IW'(2*k+1)),
      .b_dist(l_dist[2*k+1]), .b_lba(l_lba[2*k+1]),
      .y_vld (n1_vld[k]),    .y_idx (n1_idx[k]),
      .y_dist(n1_dist[k]),   .y_lba (n1_lba[k])
    );
  end

  // merge tree, second level
  for (genvar k = 0; k < 2; k++) begin : g_m2
    nlrp_pick #(.LW(LW)) u_pick (
      .a_vld (n1_vld[2*k]),   .a_idx (n1_idx[2*k]),
      .a_dist(n1_dist[2*k]),  .a_lba (n1_lba[2*k]),
      .b_vld (n1_vld[2*k+1]), .b_idx (n1_idx[2*k+1]),
      .b_dist(n1_dist[2*k+1]), .b_lba(n1_lba[2*k+1]),
      .y_vld (n2_vld[k]),     .y_idx (n2_idx[k]),
      .y_dist(n2_dist[k]),    .y_lba (n2_lba[k])
    );
  end

  // final merge
  nlrp_pick #(.LW(LW)) u_pick_fin (
    .a_vld (s2_vld_r[0]),  .a_idx (s2_idx_r[0]),
    .a_dist(s2_dist_r[0]), .a_lba (s2_lba_r[0]),
    .b_vld (s2_vld_r[1]),  .b_idx (s2_idx_r[1]),
    .b_dist(s2_dist_r[1]), .b_lba (s2_lba_r[1]),
    .y_vld (fin_vld),      .y_idx (fin_idx),
    .y_dist(),             .y_lba (fin_lba)
  );

  // control registers and per-level state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= nlrp_pkg::THRESHOLD_RESET;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < LEVELS; j++) begin
        count_r[j] <= '0;
        head_r[j]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold_r <= cfg_data;
      end
      if (s1_en) begin
        s1_v_r <= in_fire;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r;
      end
      if (out_take) begin
        out_valid_r <= s2_v_r;
      end
      // count is recorded as soon as the pass is decided
      if (in_fire && pass_nxt) begin
        count_r[lidx] <= in_request_count;
      end
      // reference LBA is recorded when the pass leaves the final merge
      if (out_take && s2_v_r && s2_pass_r) begin
        head_r[LIDX_W'(s2_lvl_r)] <= fin_lba;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (s1_en && in_fire) begin
      s1_pass_r <= pass_nxt;
      s1_lvl_r  <= in_level;
    end
    if (s2_en) begin
      s2_pass_r <= s1_pass_r;
      s2_lvl_r  <= s1_lvl_r;
      for (int k = 0; k < 2; k++) begin
        s2_vld_r[k]  <= n2_vld[k];
        s2_idx_r[k]  <= n2_idx[k];
        s2_dist_r[k] <= n2_dist[k];
        s2_lba_r[k]  <= n2_lba[k];
      end
    end
    if (out_take && s2_v_r) begin
      if (s2_pass_r && fin_vld) begin
        out_reordered_r <= 1'b1;
        out_idx_r       <= fin_idx;
        out_lba_r       <= PW'(fin_lba);
      end else begin
        out_reordered_r <= 1'b0;
        out_idx_r       <= '0;
        out_lba_r       <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_reordered    = out_reordered_r;
  assign out_chosen_index = out_idx_r;
  assign out_head_lba     = out_lba_r;

endmodule

FILE: hdl/nlrp_checker.sv
// Port-level checks for nearest_lba_request_promote, attached by bind.
// Depends on nlrp_pkg for port widths.
`timescale 1ns / 1ps

module nlrp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_reordered,
  input logic [nlrp_pkg::IDX_W-1:0]      out_chosen_index,
  input logic [nlrp_pkg::LBA_PORT_W-1:0] out_head_lba
);

  // items accepted but not yet delivered
  logic [2:0] outstanding_r;
  logic [2:0] outstanding_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    outstanding_nxt = outstanding_r;
    if (in_acc && !out_acc) begin
      outstanding_nxt = outstanding_r + 3'd1;
    end else if (!in_acc && out_acc) begin
      outstanding_nxt = outstanding_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else begin
      outstanding_r <= outstanding_nxt;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_reordered) &&
      $stable(out_chosen_index) && $stable(out_head_lba))
    else $error("result changed while stalled");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a result without a pass carries zeros
  a_nopass_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reordered |-> (out_chosen_index == '0) && (out_head_lba == '0))
    else $error("no-pass result with nonzero fields");

  // every result belongs to an accepted item
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> outstanding_r != 3'd0)
    else $error("result without an accepted item");

  // at most three items in flight
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    outstanding_r <= 3'd3)
    else $error("more items in flight than stages");

endmodule

bind nearest_lba_request_promote nlrp_checker u_nlrp_checker (.*);

FILE: sim/nlrp_checker.sv
// Scoreboard for nearest_lba_request_promote: watches the config, input and result channels,
// predicts each result from its own per-level state and compares field by field.
// Depends on nlrp_pkg for widths and defaults.
`timescale 1ns / 1ps

module nlrp_scoreboard (
  input  logic                                                        clk,
  input  logic                                                        rst_n,
  input  logic                                                        cfg_valid,
  input  logic                                                        cfg_ready,
  input  logic [nlrp_pkg::COUNT_W-1:0]                                cfg_data,
  input  logic                                                        in_valid,
  input  logic                                                        in_ready,
  input  logic [nlrp_pkg::LEVEL_W-1:0]                                in_level,
  input  logic                                                        in_dirty,
  input  logic [nlrp_pkg::COUNT_W-1:0]                                in_request_count,
  input  logic [nlrp_pkg::VALID_W-1:0]                                in_entries_valid,
  input  logic [nlrp_pkg::LBA_FIELDS-1:0][nlrp_pkg::LBA_PORT_W-1:0]   in_lbas,
  input  logic                                                        out_valid,
  input  logic                                                        out_ready,
  input  logic                                                        out_reordered,
  input  logic [nlrp_pkg::IDX_W-1:0]                                  out_chosen_index,
  input  logic [nlrp_pkg::LBA_PORT_W-1:0]                             out_head_lba,
  output int                                                          fail_count,
  output int                                                          pending
);

  localparam int COUNT_W         = nlrp_pkg::COUNT_W;
  localparam int IDX_W           = nlrp_pkg::IDX_W;
  localparam int LBA_PORT_W      = nlrp_pkg::LBA_PORT_W;
  localparam int LBA_FIELDS      = nlrp_pkg::LBA_FIELDS;
  localparam int LEVELS_DEF      = nlrp_pkg::LEVELS_DEF;
  localparam int SCAN_WINDOW_DEF = nlrp_pkg::SCAN_WINDOW_DEF;
  localparam int LBA_BITS_DEF    = nlrp_pkg::LBA_BITS_DEF;

  localparam int SCAN_LIMIT = (SCAN_WINDOW_DEF < LBA_FIELDS) ? SCAN_WINDOW_DEF : LBA_FIELDS;
  localparam logic [LBA_PORT_W-1:0] LBA_MASK = (LBA_BITS_DEF >= LBA_PORT_W) ? '1 :
                                               ({LBA_PORT_W{1'b1}} >> (LBA_PORT_W - LBA_BITS_DEF));

  typedef struct packed {
    logic                  reordered;
    logic [IDX_W-1:0]      chosen;
    logic [LBA_PORT_W-1:0] head;
  } promotion_t;

  logic [COUNT_W-1:0]    threshold;
  logic [COUNT_W-1:0]    count_at_pass [LEVELS_DEF];
  logic [LBA_PORT_W-1:0] anchor_lba [LEVELS_DEF];
  promotion_t            promotions_due [$];
  int                    mismatches;

  function automatic logic [LBA_PORT_W-1:0] seek_distance(input logic [LBA_PORT_W-1:0] a,
                                                          input logic [LBA_PORT_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Decide whether this snapshot runs a pass; if so pick the nearest entry and update state
  task automatic promote_nearest(output promotion_t p);
    int                    scan;
    int                    best;
    logic [COUNT_W-1:0]    last_count;
    logic [COUNT_W-1:0]    delta;
    logic [LBA_PORT_W-1:0] anchor;
    logic [LBA_PORT_W-1:0] best_dist;
    logic [LBA_PORT_W-1:0] span;
    p = '0;
    if (in_level >= LEVELS_DEF) return;
    scan = (in_entries_valid > SCAN_LIMIT) ? SCAN_LIMIT : int'(in_entries_valid);
    if (!in_dirty || scan < 2) return;
    last_count = count_at_pass[in_level];
    delta = (in_request_count > last_count) ? (in_request_count - last_count)
                                            : (last_count - in_request_count);
    if (delta < threshold) return;
    count_at_pass[in_level] = in_request_count;
    // earliest entry wins ties: only a strictly smaller distance replaces the pick
    anchor = anchor_lba[in_level] & LBA_MASK;
    best = 0;
    best_dist = seek_distance(in_lbas[0] & LBA_MASK, anchor);
    for (int i = 1; i < scan; i++) begin
      span = seek_distance(in_lbas[i] & LBA_MASK, anchor);
      if (span < best_dist) begin
        best_dist = span;
        best = i;
      end
    end
    anchor_lba[in_level] = in_lbas[best] & LBA_MASK;
    p.reordered = 1'b1;
    p.chosen = IDX_W'(best);
    p.head = anchor_lba[in_level];
  endtask

  task automatic field_check(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Channel monitor: config, then input, then result, all sampled at the rising edge
  always @(posedge clk) begin
    promotion_t predicted;
    promotion_t oldest;
    if (!rst_n) begin
      threshold = nlrp_pkg::THRESHOLD_RESET;
      for (int l = 0; l < LEVELS_DEF; l++) begin
        count_at_pass[l] = '0;
        anchor_lba[l] = '0;
      end
      promotions_due.delete();
      mismatches = 0;
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) threshold = cfg_data;
      if (in_valid && in_ready) begin
        promote_nearest(predicted);
        promotions_due.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (promotions_due.size() == 0) begin
          $display("%0t ns: unexpected result: expected none, actual %0b/%0d/%0h", $time,
                   out_reordered, out_chosen_index, out_head_lba);
          mismatches++;
        end else begin
          oldest = promotions_due.pop_front();
          field_check("reordered", 64'(oldest.reordered), 64'(out_reordered));
          field_check("chosen_index", 64'(oldest.chosen), 64'(out_chosen_index));
          field_check("head_lba", 64'(oldest.head), 64'(out_head_lba));
        end
      end
      fail_count <= mismatches;
      pending <= promotions_due.size();
    end
  end

endmodule

FILE: sim/nearest_lba_request_promote_tb.sv
// Testbench top for nearest_lba_request_promote: drives directed and random queue snapshots
// and threshold writes, randomizes both handshakes, and reports the verdict.
// Depends on nlrp_pkg, the block under hdl/ and nlrp_scoreboard.
`timescale 1ns / 1ps

module nearest_lba_request_promote_tb;

  localparam int LBA_FIELDS = nlrp_pkg::LBA_FIELDS;
  localparam int LBA_PORT_W = nlrp_pkg::LBA_PORT_W;
  localparam int LEVEL_W    = nlrp_pkg::LEVEL_W;
  localparam int COUNT_W    = nlrp_pkg::COUNT_W;
  localparam int VALID_W    = nlrp_pkg::VALID_W;
  localparam int IDX_W      = nlrp_pkg::IDX_W;
  localparam int LEVELS_DEF = nlrp_pkg::LEVELS_DEF;

  typedef logic [LBA_FIELDS-1:0][LBA_PORT_W-1:0] lane_set_t;

  localparam logic [LBA_PORT_W-1:0] LBA_MAX = '1;
  localparam logic [LEVEL_W-1:0]    LEVEL_TOP = '1;
  localparam int                    STALL_LIMIT = 5000;
  localparam int                    HOLD_OFF_CYCLES = 200;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [COUNT_W-1:0]    cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [LEVEL_W-1:0]    in_level;
  logic                  in_dirty;
  logic [COUNT_W-1:0]    in_request_count;
  logic [VALID_W-1:0]    in_entries_valid;
  lane_set_t             in_lbas;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_reordered;
  logic [IDX_W-1:0]      out_chosen_index;
  logic [LBA_PORT_W-1:0] out_head_lba;
  int                    fail_count;
  int                    pending;

  // stimulus knobs for the sender and receiver processes, and the watchdog counter
  bit                    tx_idle;
  bit                    rx_idle;
  int                    hold_request;
  bit                    hold_taken = 1'b0;
  logic [LEVEL_W-1:0]    recent_level;
  int                    quiet_cycles;

  nearest_lba_request_promote dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_level         (in_level),
    .in_dirty         (in_dirty),
    .in_request_count (in_request_count),
    .in_entries_valid (in_entries_valid),
    .in_lba_0         (in_lbas[0]),
    .in_lba_1         (in_lbas[1]),
    .in_lba_2         (in_lbas[2]),
    .in_lba_3         (in_lbas[3]),
    .in_lba_4         (in_lbas[4]),
    .in_lba_5         (in_lbas[5]),
    .in_lba_6         (in_lbas[6]),
    .in_lba_7         (in_lbas[7]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_reordered    (out_reordered),
    .out_chosen_index (out_chosen_index),
    .out_head_lba     (out_head_lba)
  );

  nlrp_scoreboard u_scoreboard (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_level         (in_level),
    .in_dirty         (in_dirty),
    .in_request_count (in_request_count),
    .in_entries_valid (in_entries_valid),
    .in_lbas          (in_lbas),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_reordered    (out_reordered),
    .out_chosen_index (out_chosen_index),
    .out_head_lba     (out_head_lba),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run after too many cycles without a config, input or result handshake
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic lane_set_t lba_set(input logic [LBA_PORT_W-1:0] a0, a1, a2, a3,
                                        input logic [LBA_PORT_W-1:0] a4, a5, a6, a7);
    lane_set_t s;
    s[0] = a0; s[1] = a1; s[2] = a2; s[3] = a3;
    s[4] = a4; s[5] = a5; s[6] = a6; s[7] = a7;
    return s;
  endfunction

  // Offer one snapshot; returns at the edge where it is accepted
  task automatic offer(input logic [LEVEL_W-1:0] lv, input logic dirty,
                       input logic [COUNT_W-1:0] count, input logic [VALID_W-1:0] entries,
                       input lane_set_t lanes);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_level <= lv;
    in_dirty <= dirty;
    in_request_count <= count;
    in_entries_valid <= entries;
    in_lbas <= lanes;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Mostly well-formed passes with clustered or tied LBAs; some clean, short or bad-level noise
  task automatic offer_random();
    logic [LEVEL_W-1:0]    lv;
    logic [COUNT_W-1:0]    count;
    logic [VALID_W-1:0]    entries;
    logic [LBA_PORT_W-1:0] base;
    lane_set_t             lanes;
    int                    pick;
    int                    mode;
    pick = $urandom_range(0, 99);
    if (pick < 10) lv = LEVEL_W'($urandom_range(LEVELS_DEF, int'(LEVEL_TOP)));
    else if (pick < 40) lv = recent_level;
    else lv = LEVEL_W'($urandom_range(0, LEVELS_DEF - 1));
    if (lv < LEVELS_DEF) recent_level = lv;
    case ($urandom_range(0, 3))
      0: count = '0;
      1: count = '1;
      default: count = COUNT_W'($urandom);
    endcase
    entries = ($urandom_range(0, 99) < 85) ? VALID_W'($urandom_range(2, LBA_FIELDS))
                                           : VALID_W'($urandom_range(0, 15));
    base = LBA_PORT_W'({$urandom, $urandom});
    mode = $urandom_range(0, 3);
    for (int i = 0; i < LBA_FIELDS; i++) begin
      case (mode)
        0: lanes[i] = LBA_PORT_W'({$urandom, $urandom});
        1: lanes[i] = LBA_PORT_W'($urandom_range(0, 15));
        2: lanes[i] = base + LBA_PORT_W'($urandom_range(0, 64)) - LBA_PORT_W'(32);
        default: lanes[i] = $urandom_range(0, 1) ? LBA_PORT_W'($urandom_range(0, 15))
                                                 : LBA_MAX - LBA_PORT_W'($urandom_range(0, 15));
      endcase
    end
    offer(lv, $urandom_range(0, 9) != 0, count, entries, lanes);
  endtask

  // Stop offering and wait until every expected result has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [COUNT_W-1:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int  stall;
    int  hold_len;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid && (hold_request == 0 || hold_taken));
      hold_len = (out_valid || hold_taken) ? 0 : hold_request;
      @(posedge clk);
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_taken = 1'b1;
      end
    end
  end

  // Sender: reset, directed snapshots, then random phases across threshold settings
  initial begin
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_level <= '0;
    in_dirty <= 1'b0;
    in_request_count <= '0;
    in_entries_valid <= '0;
    in_lbas <= '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_request = 0;
    recent_level = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset threshold
    offer(0, 1, 40, 2, lba_set(100, 50, 0, 0, 0, 0, 0, 0));
    // clean queue, then too few entries
    offer(0, 0, 200, 8, lba_set(1, 2, 3, 4, 5, 6, 7, 8));
    offer(0, 1, 200, 1, lba_set(1, 2, 3, 4, 5, 6, 7, 8));
    offer(0, 1, 200, 0, lba_set(1, 2, 3, 4, 5, 6, 7, 8));
    // levels past the last one
    offer(LEVEL_W'(LEVELS_DEF), 1, 200, 8, lba_set(9, 8, 7, 6, 5, 4, 3, 2));
    offer(LEVEL_W'(LEVELS_DEF + 1), 1, 200, 8, lba_set(9, 8, 7, 6, 5, 4, 3, 2));
    offer(LEVEL_TOP, 1, 200, 8, lba_set(9, 8, 7, 6, 5, 4, 3, 2));
    // count change one short of the threshold, then exactly on it
    offer(0, 1, 71, 3, lba_set(60, 40, 45, 0, 0, 0, 0, 0));
    offer(0, 1, 72, 3, lba_set(60, 40, 45, 0, 0, 0, 0, 0));
    // count drop, tie between later entries, tie on both sides of the anchor
    offer(0, 1, 8, 4, lba_set(55, 35, 45, 45, 0, 0, 0, 0));
    offer(0, 1, 100, 2, lba_set(40, 50, 0, 0, 0, 0, 0, 0));
    // entries_valid past the window, back-to-back passes on one level
    offer(1, 1, '1, '1, lba_set(LBA_MAX, LBA_MAX - 1, LBA_MAX - 2, LBA_MAX - 3,
                                LBA_MAX - 4, LBA_MAX - 5, LBA_MAX - 6, 0));
    offer(1, 1, 0, 8, lba_set(LBA_MAX, LBA_MAX, LBA_MAX, LBA_MAX,
                              LBA_MAX, LBA_MAX, LBA_MAX, LBA_MAX));
    offer(1, 1, '1, 9, lba_set(0, 1, LBA_MAX - 1, LBA_MAX, LBA_MAX, 0, 0, 0));
    offer(2, 1, 32, 8, lba_set(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, LBA_MAX, 0,
                               48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, LBA_MAX, 1));
    offer(3, 1, 16'h8000, 8, lba_set(7, 6, 5, 4, 3, 2, 1, 0));
    offer(4, 1, '1, 8, lba_set(LBA_MAX, 1, 2, 3, 4, 5, 6, 7));
    offer(2, 1, 0, 2, lba_set(48'h5555_5555_5556, 48'h5555_5555_5554, 0, 0, 0, 0, 0, 0));
    offer(2, 1, 0, 2, lba_set(48'h5555_5555_5556, 48'h5555_5555_5554, 0, 0, 0, 0, 0, 0));

    // zero threshold: an unchanged count still runs a pass
    settle();
    write_threshold('0);
    offer(3, 1, 16'h8000, 2, lba_set(9, 1, 0, 0, 0, 0, 0, 0));
    offer(3, 1, 16'h8000, 8, lba_set(5, 9, 3, 2, 2, 8, 1, 4));
    repeat (150) offer_random();

    // receiver holds off while items keep coming, so the block backs up
    settle();
    tx_idle = 1'b0;
    hold_request = HOLD_OFF_CYCLES;
    repeat (40) offer_random();
    tx_idle = 1'b1;

    // largest threshold, no idling on either side
    settle();
    write_threshold('1);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    repeat (100) offer_random();
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    settle();
    write_threshold(1);
    repeat (150) offer_random();

    settle();
    write_threshold(COUNT_W'($urandom_range(2, 200)));
    repeat (150) offer_random();

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/nlrp_pkg.sv
hdl/nlrp_lane.sv
hdl/nlrp_pick.sv
hdl/nearest_lba_request_promote.sv
hdl/nlrp_checker.sv
sim/nlrp_checker.sv
sim/nearest_lba_request_promote_tb.sv
